// ----- src/apq_pkg.sv -----
// Package for the array priority queue: sizes, codes and the shared structs.
package apq_pkg;

   localparam int DEPTH = 8;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int RANK_W = 8;
   localparam int FILL_W = 4;
   localparam int STATUS_W = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

   // Running best candidate that travels along the chain of cells.
   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
      logic [DATA_W-1:0] value;
      logic [IDX_W-1:0]  idx;
   } scan_type;

   // Commands broadcast from the controller to every cell.
   typedef struct packed {
      logic             write;
      logic             shift;
      logic [IDX_W-1:0] target;
      logic [CNT_W-1:0] occupancy;
   } ctrl_type;

endpackage

// ----- src/apq_cell.sv -----
// One storage cell of the priority queue with its stage of the search chain.
module apq_cell
   import apq_pkg::*;
(
   input  logic              clock,
   input  logic [IDX_W-1:0]  cell_index,
   input  ctrl_type          ctrl,
   input  logic [DATA_W-1:0] wr_value,
   input  logic [RANK_W-1:0] wr_rank,
   input  logic [DATA_W-1:0] next_value,
   input  logic [RANK_W-1:0] next_rank,
   input  scan_type          scan_in,
   output logic [DATA_W-1:0] value,
   output logic [RANK_W-1:0] rank,
   output scan_type          scan_out
);

   logic [DATA_W-1:0] value_ff, value_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   scan_type          scan_ff, scan_next_in;
   logic              active;

   assign active = {1'b0, cell_index} < {1'b0, ctrl.occupancy};

   always_comb begin
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctrl.write && (ctrl.target == cell_index)) begin
         value_in = wr_value;
         rank_in  = wr_rank;
      end else if (ctrl.shift && (cell_index >= ctrl.target)) begin
         value_in = next_value;
         rank_in  = next_rank;
      end
   end

   // An earlier candidate wins ties; an active cell takes over when no candidate is held yet or when strictly larger.
   always_comb begin
      scan_next_in = scan_in;
      if (active && (!scan_in.valid || (rank_ff > scan_in.rank))) begin
         scan_next_in.valid = 1'b1;
         scan_next_in.rank  = rank_ff;
         scan_next_in.value = value_ff;
         scan_next_in.idx   = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rank_ff  <= rank_in;
      scan_ff  <= scan_next_in;
   end

   assign value    = value_ff;
   assign rank     = rank_ff;
   assign scan_out = scan_ff;

endmodule

// ----- src/array_priority_queue.sv -----
// Top level of the array priority queue: controller, result register and cell chain.
//
// The request channel carries one command per transaction: an enqueue of a data
// word with its priority, or a dequeue of the entry with the largest priority
// (the earliest one among equal priorities). Every request produces exactly one
// transaction on the response channel with the data, a status code and the
// number of entries held afterwards.
// Enqueue, overflow and underflow answer in the cycle after acceptance, and the
// next request can be taken in the cycle the response is shown, so these run
// at one transaction per cycle while the receiver does not stall.
// A dequeue of a non-empty queue answers once the search is done: the search for
// the best entry is a wave that moves one cell per cycle along the chain of DEPTH
// cells, then the shift state closes the gap and loads the response. No new
// request is taken until that response is loaded.
// A synchronous, active-high reset empties the queue and drops any pending
// response; stored entries are not cleared and are never read before written.
// While the receiver stalls, the response is held and no new request is taken.
module array_priority_queue
   import apq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic signed [DATA_W-1:0] req_item_data,
   input  logic        [RANK_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_out_data,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic        [FILL_W-1:0] rsp_fill_level
);

   // Controller states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic                req_accept;
   logic                rsp_free;
   ctrl_type            ctrl;

   logic [DATA_W-1:0]   cell_value [DEPTH];
   logic [RANK_W-1:0]   cell_rank  [DEPTH];
   logic [DATA_W-1:0]   cell_next_value [DEPTH];
   logic [RANK_W-1:0]   cell_next_rank  [DEPTH];
   scan_type            scan_link [DEPTH+1];

   // The response register can take a new result when empty or being drained.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      occ_in        = occ_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      ctrl.write     = 1'b0;
      ctrl.shift     = 1'b0;
      ctrl.target    = occ_ff[IDX_W-1:0];
      ctrl.occupancy = occ_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (occ_ff == CNT_W'(DEPTH)) begin
                     rsp_status_in = ST_OVERFLOW;
                     rsp_fill_in   = FILL_W'(occ_ff);
                  end else begin
                     ctrl.write    = 1'b1;
                     occ_in        = occ_ff + CNT_W'(1);
                     rsp_status_in = ST_ENQUEUED;
                     rsp_fill_in   = FILL_W'(occ_ff + CNT_W'(1));
                  end
               end else if (occ_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '0;
                  rsp_status_in = ST_UNDERFLOW;
                  rsp_fill_in   = '0;
               end else begin
                  // Let the search wave run through every cell of the chain.
                  state_in = S_SCAN;
                  cnt_in   = '0;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(DEPTH - 1)) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // The end of the chain now holds the winner; close the gap behind it.
            ctrl.shift    = 1'b1;
            ctrl.target   = scan_link[DEPTH].idx;
            occ_in        = occ_ff - CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_data_in   = scan_link[DEPTH].value;
            rsp_status_in = ST_DEQUEUED;
            rsp_fill_in   = FILL_W'(occ_ff - CNT_W'(1));
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_data   = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_level = rsp_fill_ff;

   // The head of the search chain starts with no candidate.
   assign scan_link[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign cell_next_value[i] = cell_value[i];
         assign cell_next_rank[i]  = cell_rank[i];
      end else begin : g_inner
         assign cell_next_value[i] = cell_value[i+1];
         assign cell_next_rank[i]  = cell_rank[i+1];
      end

      apq_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .wr_value   (req_item_data),
         .wr_rank    (req_item_priority),
         .next_value (cell_next_value[i]),
         .next_rank  (cell_next_rank[i]),
         .scan_in    (scan_link[i]),
         .value      (cell_value[i]),
         .rank       (cell_rank[i]),
         .scan_out   (scan_link[i+1])
      );
   end

`ifndef SYNTH
   // The fill count never goes beyond the number of cells.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   // No response is pending while a dequeue is being worked on.
   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending during dequeue");

   // When the gap is closed the chain must deliver a real candidate.
   a_shift_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (scan_link[DEPTH].valid && (occ_ff != '0)))
      else $error("dequeue without a winning entry");

   // A stored enqueue raises the fill count by exactly one.
   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_ENQUEUE) && (occ_ff != CNT_W'(DEPTH)))
      |=> (occ_ff == $past(occ_ff) + CNT_W'(1)))
      else $error("enqueue did not advance occupancy");
`endif

endmodule

// ----- test/apq_checker.sv -----
// Checker for the array priority queue: predicts every response and compares it.
module apq_checker
   import apq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic                     req_cmd,
   input  logic signed [DATA_W-1:0] req_item_data,
   input  logic        [RANK_W-1:0] req_item_priority,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_out_data,
   input  logic      [STATUS_W-1:0] rsp_status,
   input  logic        [FILL_W-1:0] rsp_fill_level,
   output int                       fail_count,
   output int                       pending,
   output int                       checked,
   output int                       dequeued,
   output int                       overflowed,
   output int                       underflowed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [FILL_W-1:0]        fill;
   } answer_type;

   // Shadow copy of the queue contents, kept in arrival order.
   logic signed [DATA_W-1:0] shadow_value [DEPTH];
   logic [RANK_W-1:0]        shadow_rank [DEPTH];
   int                       held;
   answer_type               answers_due [$];

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
      dequeued = 0;
      overflowed = 0;
      underflowed = 0;
      held = 0;
   end

   function automatic answer_type serve_request(input logic cmd,
                                                input logic signed [DATA_W-1:0] data,
                                                input logic [RANK_W-1:0] prio);
      answer_type ans;
      int best;
      ans.data = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (held >= DEPTH) begin
            ans.status = ST_OVERFLOW;
         end else begin
            shadow_value[held] = data;
            shadow_rank[held] = prio;
            held++;
            ans.status = ST_ENQUEUED;
         end
      end else if (held == 0) begin
         ans.status = ST_UNDERFLOW;
      end else begin
         // Only a strictly larger rank displaces the current best, so ties go to the oldest.
         best = 0;
         for (int i = 1; i < held; i++) begin
            if (shadow_rank[i] > shadow_rank[best]) best = i;
         end
         ans.data = shadow_value[best];
         for (int i = best; i + 1 < held; i++) begin
            shadow_value[i] = shadow_value[i + 1];
            shadow_rank[i] = shadow_rank[i + 1];
         end
         held--;
         ans.status = ST_DEQUEUED;
      end
      ans.fill = FILL_W'(held);
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type due;
      if (reset) begin
         held = 0;
         answers_due.delete();
      end else begin
         // Responses are checked before the request of the same edge is predicted.
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response with nothing expected: data %0d status %0d fill %0d",
                        $time, rsp_out_data, rsp_status, rsp_fill_level);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               checked++;
               if (due.status == ST_DEQUEUED) dequeued++;
               if (due.status == ST_OVERFLOW) overflowed++;
               if (due.status == ST_UNDERFLOW) underflowed++;
               if (rsp_out_data !== due.data) begin
                  $display("%0t: out_data mismatch: expected %0d, actual %0d",
                           $time, due.data, rsp_out_data);
                  fail_count++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, due.status, rsp_status);
                  fail_count++;
               end
               if (rsp_fill_level !== due.fill) begin
                  $display("%0t: fill_level mismatch: expected %0d, actual %0d",
                           $time, due.fill, rsp_fill_level);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            answers_due.push_back(serve_request(req_cmd, req_item_data, req_item_priority));
         end
      end
      pending = answers_due.size();
   end

endmodule

// ----- test/testbench.sv -----
// Top of the array priority queue regression: clock, reset, stimulus and verdict.
module testbench
   import apq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here; a correct run needs a small fraction of it.
   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_ITEMS = 950;

   typedef enum {STALL_NONE, STALL_SPARSE, STALL_LONG} stall_mode_type;
   typedef enum {PRIO_ANY, PRIO_CLUSTER, PRIO_EXTREME} prio_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = CMD_ENQUEUE;
   logic signed [DATA_W-1:0] req_item_data = '0;
   logic        [RANK_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_data;
   logic      [STATUS_W-1:0] rsp_status;
   logic        [FILL_W-1:0] rsp_fill_level;

   int fail_count;
   int pending;
   int checked;
   int dequeued;
   int overflowed;
   int underflowed;

   int             cycle_count = 0;
   int             sent = 0;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   array_priority_queue uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_data      (rsp_out_data),
      .rsp_status        (rsp_status),
      .rsp_fill_level    (rsp_fill_level)
   );

   // The checker sits beside the block and sees exactly the same pins.
   apq_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_data      (rsp_out_data),
      .rsp_status        (rsp_status),
      .rsp_fill_level    (rsp_fill_level),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked),
      .dequeued          (dequeued),
      .overflowed        (overflowed),
      .underflowed       (underflowed)
   );

   // A 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: if the block hangs, the run still ends with a verdict.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending);
         $display("array_priority_queue regression: fail");
         $finish;
      end
   end

   // The receiver switches between patterns at random: no stall at all, scattered
   // random stalls, and long stalls that hold a response. The stalls land on every
   // phase of the search wave as well as on enqueue, overflow and underflow responses.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 2));
         stall_left <= $urandom_range(20, 120);
         rsp_stall <= 1'b0;
      end else begin
         stall_left <= stall_left - 1;
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_SPARSE: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               rsp_stall <= ((stall_left % 16) < 9);
            end
         endcase
      end
   end

   // Presents one transaction and holds it until the block takes it. The sender
   // works in bursts: when a burst runs out, it usually drops valid for a random
   // gap, otherwise the next burst follows back to back. The data lines carry
   // noise while valid is low.
   task automatic issue(input logic cmd, input logic signed [DATA_W-1:0] data,
                        input logic [RANK_W-1:0] prio);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_item_data <= data;
      req_item_priority <= prio;
      do @(posedge clock); while (req_stall);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            req_item_data <= $urandom();
            req_item_priority <= RANK_W'($urandom());
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      int            phase_left;
      int            enqueue_pct;
      int            random_sent;
      prio_mode_type prio_mode;
      logic          cmd;
      logic [RANK_W-1:0] prio;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty queue must report underflow first.
      issue(CMD_DEQUEUE, $urandom(), RANK_W'($urandom()));
      // Fill the queue with extreme data words and priorities, including ties at
      // the top rank and at the bottom rank so that arrival order decides.
      issue(CMD_ENQUEUE, 32'sh7fff_ffff, 8'd0);
      issue(CMD_ENQUEUE, 32'sh8000_0000, 8'd255);
      issue(CMD_ENQUEUE, -32'sd1, 8'd255);
      issue(CMD_ENQUEUE, 32'sd0, 8'd128);
      issue(CMD_ENQUEUE, 32'sh5555_5555, 8'd0);
      issue(CMD_ENQUEUE, 32'shaaaa_aaaa, 8'd1);
      issue(CMD_ENQUEUE, 32'sd1, 8'd254);
      issue(CMD_ENQUEUE, 32'sh1234_5678, 8'd255);
      // The queue is full now, so these two must overflow and change nothing.
      issue(CMD_ENQUEUE, 32'shdead_beef, 8'd7);
      issue(CMD_ENQUEUE, 32'sh8000_0000, 8'd255);
      // Drain it completely; data and priority on a dequeue are don't-cares.
      repeat (DEPTH) issue(CMD_DEQUEUE, $urandom(), RANK_W'($urandom()));
      issue(CMD_DEQUEUE, $urandom(), RANK_W'($urandom()));
      // A single entry in and out, then underflow again.
      issue(CMD_ENQUEUE, $urandom(), 8'd0);
      issue(CMD_DEQUEUE, $urandom(), RANK_W'($urandom()));
      issue(CMD_DEQUEUE, $urandom(), RANK_W'($urandom()));

      // Random part. Phases lean toward enqueue, toward dequeue, or neither, so
      // the fill level keeps sweeping between empty and full. The priority mode
      // picks between the full range, a narrow cluster that forces many ties,
      // and only the two extreme ranks.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         phase_left = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: enqueue_pct = 85;
            1: enqueue_pct = 15;
            default: enqueue_pct = 50;
         endcase
         prio_mode = prio_mode_type'($urandom_range(0, 2));
         while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
            cmd = ($urandom_range(0, 99) < enqueue_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
            case (prio_mode)
               PRIO_ANY: begin
                  prio = RANK_W'($urandom());
               end
               PRIO_CLUSTER: begin
                  prio = RANK_W'($urandom_range(0, 3));
               end
               default: begin
                  prio = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
               end
            endcase
            issue(cmd, $urandom(), prio);
            phase_left--;
            random_sent++;
         end
      end
      req_valid <= 1'b0;

      // Wait for every outstanding response, then a little longer than one
      // dequeue takes, so a stray extra response would still be caught. The
      // first edge lets the checker count the last request before it is polled.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);

      $display("%0d requests sent, %0d responses checked in %0d cycles", sent, checked,
               cycle_count);
      $display("%0d dequeues served, %0d overflows, %0d underflows, %0d mismatches",
               dequeued, overflowed, underflowed, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("array_priority_queue regression: pass");
      end else begin
         $display("array_priority_queue regression: fail");
      end
      $finish;
   end

endmodule

// ----- array_priority_queue.f -----
src/apq_pkg.sv
src/apq_cell.sv
src/array_priority_queue.sv
test/apq_checker.sv
test/testbench.sv
